// ===== hdl/sfme_pkg.sv =====
// Shared types and constants for the symbol frequency / min-extract block.
// Used by symbol_frequency_min_extract_core and the testbench; no dependencies.
`default_nettype none

package sfme_pkg;

   // default configuration
   localparam int DEF_NUM_SYMBOLS = 127;
   localparam int DEF_COUNT_BITS  = 32;

   // fixed widths of the item fields
   localparam int SYMBOL_BITS   = 8;
   localparam int MIN_SYM_BITS  = 7;
   localparam int MIN_FREQ_BITS = 32;

   typedef enum logic {
      OP_COUNT = 1'b0,
      OP_POP   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_COUNTED = 2'd0,
      STATUS_POPPED  = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic [SYMBOL_BITS-1:0] symbol;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [MIN_SYM_BITS-1:0]  min_symbol;
      logic [MIN_FREQ_BITS-1:0] min_frequency;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/symbol_frequency_min_extract_core.sv =====
// Top level of the symbol frequency counter with minimum extraction.
// Depends on sfme_pkg and sfme_ram.
`default_nettype none

// Usage
//   Input channel: an item (req_item) is taken on a clock edge where start
//   is high and busy is low. op = count adds one to the symbol's frequency
//   (saturating) and marks it present; op = pop removes the present symbol
//   with the lowest frequency (lowest code on ties) and reports it.
//   Result channel: exactly one result per item, shown on rsp_item for one
//   cycle while rsp_valid is high. The receiver cannot stall; every result
//   is taken in the cycle it appears.
//   Sequence per item:
//     out-of-range count: result in the cycle after accept, busy stays low.
//     count: the frequency RAM is read at accept, then ST_COUNT writes it
//       back and registers the result; busy is high for one cycle.
//     pop: ST_SCAN reads one frequency RAM entry per cycle through its one
//       read port, each registered read is folded into the running
//       minimum, and ST_DRAIN registers the result.
//   Reset: synchronous, active high. Present flags live in flip-flops and
//   are cleared at once; a frequency entry whose symbol is not present
//   reads as zero, so the RAM needs no clearing pass and items may be
//   accepted in the first cycle after reset.
module symbol_frequency_min_extract_core #(
   parameter int NUM_SYMBOLS = sfme_pkg::DEF_NUM_SYMBOLS,
   parameter int COUNT_BITS  = sfme_pkg::DEF_COUNT_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire sfme_pkg::req_type req_item,
   output logic                   rsp_valid,
   output sfme_pkg::rsp_type      rsp_item
);

   localparam int IW = $clog2(NUM_SYMBOLS);
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SYMBOLS - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // state and control registers
   sfme_pkg::state_type     state_ff, state_in;
   logic [NUM_SYMBOLS-1:0]  present_ff, present_in;
   logic [IW-1:0]           addr_ff, addr_in;
   logic [IW-1:0]           cnt_idx_ff, cnt_idx_in;
   logic                    sample_valid_ff, sample_valid_in;
   logic                    sample_present_ff, sample_present_in;
   logic [IW-1:0]           sample_idx_ff, sample_idx_in;
   logic                    best_found_ff, best_found_in;
   logic [IW-1:0]           best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0]   best_cnt_ff, best_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sfme_pkg::rsp_type       rsp_item_ff, rsp_item_in;

   // RAM ports
   logic                  ram_wr_en, ram_rd_en;
   logic [IW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;

   // combinational helpers
   logic                  accept;
   logic                  sym_in_range;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic                  take;
   logic                  win_found;
   logic [IW-1:0]         win_idx;
   logic [COUNT_BITS-1:0] win_cnt;
   logic [63:0]           best_cnt_ext;
   logic [15:0]           best_idx_ext;

   assign busy         = (state_ff != sfme_pkg::ST_IDLE);
   assign accept       = start && !busy;
   assign sym_in_range = ({1'b0, req_item.symbol} < 9'(NUM_SYMBOLS));

   sfme_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_SYMBOLS)
   ) u_freq_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfme_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_item.op == sfme_pkg::OP_POP) begin
                  state_in = sfme_pkg::ST_SCAN;
               end else if (sym_in_range) begin
                  state_in = sfme_pkg::ST_COUNT;
               end
            end
         end
         sfme_pkg::ST_COUNT: state_in = sfme_pkg::ST_IDLE;
         sfme_pkg::ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = sfme_pkg::ST_DRAIN;
            end
         end
         sfme_pkg::ST_DRAIN: state_in = sfme_pkg::ST_IDLE;
         default: state_in = sfme_pkg::ST_IDLE;
      endcase
   end

   // scan candidate: a present entry beats the running best if smaller
   assign take = sample_valid_ff && sample_present_ff &&
                 (!best_found_ff || (ram_rd_data < best_cnt_ff));

   // running best with the sample on the RAM output folded in
   assign win_found    = best_found_ff || take;
   assign win_idx      = take ? sample_idx_ff : best_idx_ff;
   assign win_cnt      = take ? ram_rd_data : best_cnt_ff;
   assign best_cnt_ext = 64'(win_cnt);
   assign best_idx_ext = 16'(win_idx);

   // outputs and datapath
   always_comb begin
      present_in        = present_ff;
      addr_in           = addr_ff;
      cnt_idx_in        = cnt_idx_ff;
      sample_valid_in   = 1'b0;
      sample_present_in = 1'b0;
      sample_idx_in     = addr_ff;
      best_found_in     = best_found_ff;
      best_idx_in       = best_idx_ff;
      best_cnt_in       = best_cnt_ff;
      rsp_valid_in      = 1'b0;
      rsp_item_in       = '0;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = addr_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = cnt_idx_ff;
      ram_wr_data       = '0;
      cur_cnt           = present_ff[cnt_idx_ff] ? ram_rd_data : '0;

      // running minimum across scan samples
      if (take) begin
         best_found_in = 1'b1;
         best_idx_in   = sample_idx_ff;
         best_cnt_in   = ram_rd_data;
      end

      unique case (state_ff)
         sfme_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_item.op == sfme_pkg::OP_POP) begin
                  addr_in       = '0;
                  best_found_in = 1'b0;
               end else if (sym_in_range) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_item.symbol[IW-1:0];
                  cnt_idx_in  = req_item.symbol[IW-1:0];
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = sfme_pkg::STATUS_RANGE;
               end
            end
         end
         sfme_pkg::ST_COUNT: begin
            // read-modify-write of the counted entry
            ram_wr_en   = 1'b1;
            ram_wr_data = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
            present_in[cnt_idx_ff] = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_item_in.status = sfme_pkg::STATUS_COUNTED;
         end
         sfme_pkg::ST_SCAN: begin
            ram_rd_en         = 1'b1;
            sample_valid_in   = 1'b1;
            sample_present_in = present_ff[addr_ff];
            sample_idx_in     = addr_ff;
            if (addr_ff != LAST_IDX) begin
               addr_in = addr_ff + IW'(1);
            end
         end
         sfme_pkg::ST_DRAIN: begin
            // last sample folded in above; report and remove the winner
            rsp_valid_in = 1'b1;
            if (win_found) begin
               present_in[win_idx]       = 1'b0;
               rsp_item_in.status        = sfme_pkg::STATUS_POPPED;
               rsp_item_in.min_symbol    = best_idx_ext[sfme_pkg::MIN_SYM_BITS-1:0];
               rsp_item_in.min_frequency = best_cnt_ext[sfme_pkg::MIN_FREQ_BITS-1:0];
            end else begin
               rsp_item_in.status = sfme_pkg::STATUS_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sfme_pkg::ST_IDLE;
         present_ff      <= '0;
         sample_valid_ff <= 1'b0;
         best_found_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         present_ff      <= present_in;
         sample_valid_ff <= sample_valid_in;
         best_found_ff   <= best_found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff           <= addr_in;
      cnt_idx_ff        <= cnt_idx_in;
      sample_present_ff <= sample_present_in;
      sample_idx_ff     <= sample_idx_in;
      best_idx_ff       <= best_idx_in;
      best_cnt_ff       <= best_cnt_in;
      rsp_item_ff       <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== hdl/sfme_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module sfme_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 127
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for symbol_frequency_min_extract_core: counts and pops are checked
// against an in-bench frequency table. Depends on sfme_pkg and the core RTL.

module tb;

   localparam int NUM_SYM      = sfme_pkg::DEF_NUM_SYMBOLS;
   localparam int RANDOM_ITEMS = 650;
   localparam int NO_IDLE_TAIL = 60;
   localparam int STALL_LIMIT  = 2000;
   localparam logic [sfme_pkg::DEF_COUNT_BITS-1:0] CNT_MAX = '1;

   // one item waiting to go out; drain_first holds it until all results are in
   typedef struct {
      sfme_pkg::req_type item;
      bit                drain_first;
   } pending_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   sfme_pkg::req_type req_item = '0;
   logic              rsp_valid;
   sfme_pkg::rsp_type rsp_item;

   pending_item_type  stim_q[$];
   sfme_pkg::rsp_type expect_q[$];
   logic [sfme_pkg::DEF_COUNT_BITS-1:0] freq_table [NUM_SYM];
   logic [NUM_SYM-1:0]                  present_mask;

   int err_count   = 0;
   int gap_left    = 0;
   int stall_count = 0;
   sfme_pkg::rsp_type want;

   symbol_frequency_min_extract_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frequency table update and expected result for one accepted item
   function automatic sfme_pkg::rsp_type predict_item(sfme_pkg::req_type item);
      sfme_pkg::rsp_type r;
      int best;
      r = '0;
      best = -1;
      if (item.op == sfme_pkg::OP_COUNT) begin
         if (item.symbol >= NUM_SYM) begin
            r.status = sfme_pkg::STATUS_RANGE;
         end else begin
            if (freq_table[item.symbol] != CNT_MAX)
               freq_table[item.symbol] = freq_table[item.symbol] + 1'b1;
            present_mask[item.symbol] = 1'b1;
            r.status = sfme_pkg::STATUS_COUNTED;
         end
      end else begin
         // ascending scan, strict less-than keeps the lowest code on ties
         for (int i = 0; i < NUM_SYM; i++)
            if (present_mask[i] && (best < 0 || freq_table[i] < freq_table[best]))
               best = i;
         if (best < 0) begin
            r.status = sfme_pkg::STATUS_EMPTY;
         end else begin
            r.status        = sfme_pkg::STATUS_POPPED;
            r.min_symbol    = best[sfme_pkg::MIN_SYM_BITS-1:0];
            r.min_frequency = freq_table[best][sfme_pkg::MIN_FREQ_BITS-1:0];
            present_mask[best] = 1'b0;
            freq_table[best]   = '0;
         end
      end
      return r;
   endfunction

   task automatic add_item(sfme_pkg::op_type op, int symbol, bit drain_first);
      pending_item_type p;
      p.item.op     = op;
      p.item.symbol = symbol[sfme_pkg::SYMBOL_BITS-1:0];
      p.drain_first = drain_first;
      stim_q.push_back(p);
   endtask

   // driver: hold the item until taken, then idle or present the next one
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
         for (int i = 0; i < NUM_SYM; i++)
            freq_table[i] = '0;
         present_mask = '0;
      end else begin
         if (start && !busy)
            expect_q.push_back(predict_item(req_item));
         if (start && busy) begin
            // still waiting for the block to take the item
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (stim_q.size() == 0) begin
            start <= 1'b0;
         end else if (stim_q[0].drain_first && expect_q.size() != 0) begin
            start <= 1'b0;
         end else if (stim_q.size() > NO_IDLE_TAIL && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(1, 15) - 1;
            start    <= 1'b0;
         end else begin
            req_item <= stim_q[0].item;
            start    <= 1'b1;
            void'(stim_q.pop_front());
         end
      end
   end

   // monitor: every strobe is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expect_q.size() == 0) begin
            $error("result with nothing expected: status %0d", rsp_item.status);
            err_count++;
         end else begin
            want = expect_q.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
               err_count++;
            end
            if (rsp_item.min_symbol !== want.min_symbol) begin
               $error("min_symbol: expected %0d, actual %0d",
                      want.min_symbol, rsp_item.min_symbol);
               err_count++;
            end
            if (rsp_item.min_frequency !== want.min_frequency) begin
               $error("min_frequency: expected %0d, actual %0d",
                      want.min_frequency, rsp_item.min_frequency);
               err_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item taken and no result seen
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      int made, phase_len, pop_pct, span, base, r;
      made = 0;

      // directed: empty pop, range edges, ties, removal and restart
      add_item(sfme_pkg::OP_POP,   0,   1'b0);
      add_item(sfme_pkg::OP_COUNT, 0,   1'b0);
      add_item(sfme_pkg::OP_COUNT, 126, 1'b0);
      add_item(sfme_pkg::OP_COUNT, 127, 1'b0);
      add_item(sfme_pkg::OP_COUNT, 255, 1'b0);
      add_item(sfme_pkg::OP_COUNT, 128, 1'b0);
      add_item(sfme_pkg::OP_COUNT, 126, 1'b0);
      add_item(sfme_pkg::OP_POP,   255, 1'b1);
      add_item(sfme_pkg::OP_COUNT, 64,  1'b0);
      add_item(sfme_pkg::OP_COUNT, 1,   1'b0);
      add_item(sfme_pkg::OP_POP,   0,   1'b0);
      add_item(sfme_pkg::OP_POP,   0,   1'b0);
      add_item(sfme_pkg::OP_POP,   0,   1'b0);
      add_item(sfme_pkg::OP_POP,   0,   1'b0);
      add_item(sfme_pkg::OP_COUNT, 126, 1'b0);
      add_item(sfme_pkg::OP_POP,   0,   1'b0);
      add_item(sfme_pkg::OP_COUNT, 85,  1'b0);
      add_item(sfme_pkg::OP_COUNT, 42,  1'b0);
      add_item(sfme_pkg::OP_COUNT, 42,  1'b0);
      add_item(sfme_pkg::OP_COUNT, 85,  1'b0);
      add_item(sfme_pkg::OP_POP,   170, 1'b0);
      add_item(sfme_pkg::OP_POP,   85,  1'b0);
      add_item(sfme_pkg::OP_POP,   0,   1'b0);

      // random phases: a pool of symbols, a pop rate, then maybe a drain
      while (made < RANDOM_ITEMS) begin
         phase_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: pop_pct = 5;
            1: pop_pct = 20;
            default: pop_pct = 45;
         endcase
         span = ($urandom_range(0, 3) == 0) ? 126 : $urandom_range(0, 7);
         case ($urandom_range(0, 3))
            0: base = 0;
            1: base = 126 - span;
            default: base = $urandom_range(0, 126 - span);
         endcase
         for (int k = 0; k < phase_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < pop_pct)
               add_item(sfme_pkg::OP_POP, $urandom_range(0, 255),
                        k == 0 && $urandom_range(0, 3) == 0);
            else if (r < pop_pct + 6)
               add_item(sfme_pkg::OP_COUNT, $urandom_range(NUM_SYM, 255), 1'b0);
            else
               add_item(sfme_pkg::OP_COUNT, base + $urandom_range(0, span), 1'b0);
            made++;
         end
         if ($urandom_range(0, 1) == 0) begin
            r = (span < 16) ? $urandom_range(span + 1, span + 4) : $urandom_range(1, 10);
            for (int k = 0; k < r; k++)
               add_item(sfme_pkg::OP_POP, $urandom_range(0, 255), 1'b0);
            made += r;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || start)
         @(posedge clock);
      while (expect_q.size() != 0)
         @(posedge clock);
      repeat (NUM_SYM + 10) @(posedge clock);

      if (expect_q.size() != 0) begin
         $error("%0d results never arrived", expect_q.size());
         err_count++;
      end
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
